[rtl/adcsl_pkg.sv]
// shared constants for the audio declick, dc blocker and soft limiter block
package adcsl_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 16;
	localparam int RAMP_W   = 11;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W = SAMPLE_W + LEN_W;

	localparam logic [RAMP_W-1:0] MAX_RAMP = 11'd1024;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] REG_LIM_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_KNEE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DCL_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DCL_RAMP_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DC_BETA       = 3'd4;

endpackage

[rtl/audio_declick_dc_block_soft_limit.sv]
// audio declick, dc blocker and soft limiter with one shared multiplier and divider
//
// channel  | direction | tdata                                  | tuser
// s_axis   | in        | [15:0] sample_in, [31:16] chunk_length | chunk_start
// m_axis   | out       | [15:0] sample_out                      | -
// cfg      | in        | cfg_data written to register cfg_index  | -
//
// one request at a time: without ramp and limiting it passes ST_FMUL, ST_FADD and ST_OUT;
// the ramp adds ST_RMUL, ST_RLD, ST_DIV and ST_RFIN before these,
// the limiter ST_LMUL, ST_LLD, ST_DIV and ST_LFIN after ST_FADD;
// ST_DIV runs the serial divider (16 steps for the ramp, 15 steps for the limiter)
// s_tready is high only while the sequencer waits for a request
// a finished result sits in the output register; the next request may be taken meanwhile
// arst_n clears all state, config takes its reset values
module audio_declick_dc_block_soft_limit
	import adcsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // [15:0] sample_in, [31:16] chunk_length
	input  logic                 s_tuser,   // chunk_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RMUL = 4'd1;
	localparam logic [3:0] ST_RLD  = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_RFIN = 4'd4;
	localparam logic [3:0] ST_FMUL = 4'd5;
	localparam logic [3:0] ST_FADD = 4'd6;
	localparam logic [3:0] ST_LMUL = 4'd7;
	localparam logic [3:0] ST_LLD  = 4'd8;
	localparam logic [3:0] ST_LFIN = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [3:0] state_q;

	logic [14:0]       lim_thr_q;
	logic [14:0]       lim_knee_q;
	logic [15:0]       dcl_thr_q;
	logic [RAMP_W-1:0] ramp_len_q;
	logic [14:0]       beta_q;

	logic              seen_q;
	logic [15:0]       last_q;
	logic [15:0]       prev_in_q;
	logic [31:0]       prev_out_q;
	logic              ramp_act_q;
	logic [15:0]       origin_q;
	logic [RAMP_W-1:0] span_q;
	logic [RAMP_W-1:0] pos_q;

	logic [15:0]        x_q;
	logic               dneg_q;
	logic               yneg_q;
	logic signed [32:0] over_q;
	logic signed [49:0] prod_q;
	logic [32:0]        rem_q;
	logic [32:0]        dsor_q;
	logic [15:0]        lo_q;
	logic [15:0]        quo_q;
	logic [4:0]         cnt_q;
	logic               div_ramp_q;
	logic [15:0]        res_q;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	logic               accept;
	logic [16:0]        jump, jump_mag;
	logic [RAMP_W-1:0]  rl_sat, ramp_n, pos_inc;
	logic [15:0]        len_in;
	logic               start_ramp;
	logic [16:0]        d, d_mag;
	logic signed [32:0] mul_a;
	logic [15:0]        mul_b;
	logic signed [49:0] mul_p;
	logic [33:0]        div_t, div_diff;
	logic               div_ge;
	logic [17:0]        q_ext, m_sum;
	logic [15:0]        ramp_x;
	logic signed [49:0] fq;
	logic [49:0]        y_full;
	logic signed [31:0] y;
	logic [32:0]        y_abs;
	logic               y_small;
	logic [15:0]        y_clamp;
	logic [15:0]        lim_c, lim_sat, lim_res;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		// declick check on a chunk's first sample
		jump     = {s_tdata[15], s_tdata[15:0]} - {last_q[15], last_q};
		jump_mag = jump[16] ? (17'd0 - jump) : jump;
		rl_sat   = (ramp_len_q > MAX_RAMP) ? MAX_RAMP : ramp_len_q;
		len_in   = s_tdata[IN_DATA_W-1:SAMPLE_W];
		ramp_n   = ({5'd0, rl_sat} > len_in) ? len_in[RAMP_W-1:0] : rl_sat;
		start_ramp = seen_q && (jump_mag >= {1'b0, dcl_thr_q}) && (ramp_n != '0);

		d       = {x_q[15], x_q} - {origin_q[15], origin_q};
		d_mag   = d[16] ? (17'd0 - d) : d;
		pos_inc = pos_q + 11'd1;

		// shared multiplier
		case (state_q)
			ST_RMUL: begin
				mul_a = {16'd0, d_mag};
				mul_b = {5'd0, pos_inc};
			end
			ST_FMUL: begin
				mul_a = {prev_out_q[31], prev_out_q};
				mul_b = {1'b0, beta_q};
			end
			default: begin
				mul_a = over_q;
				mul_b = {1'b0, lim_knee_q};
			end
		endcase
		mul_p = mul_a * $signed({1'b0, mul_b});

		// shared restoring divider step
		div_t    = {rem_q, lo_q[15]};
		div_ge   = div_t >= {1'b0, dsor_q};
		div_diff = div_t - {1'b0, dsor_q};

		// ramp value
		q_ext  = {2'd0, quo_q};
		m_sum  = {{2{origin_q[15]}}, origin_q} + (dneg_q ? (18'd0 - q_ext) : q_ext);
		if (!m_sum[17] && (m_sum[16:15] != 2'b00))
			ramp_x = SAMPLE_MAX;
		else if (m_sum[17] && (m_sum[16:15] != 2'b11))
			ramp_x = SAMPLE_MIN;
		else
			ramp_x = m_sum[15:0];

		// dc blocker
		fq     = prod_q >>> 15;
		y_full = {{34{x_q[15]}}, x_q} - {{34{prev_in_q[15]}}, prev_in_q} + fq;
		y      = y_full[31:0];
		y_abs  = y[31] ? (33'd0 - {y[31], y}) : {y[31], y};
		y_small = y_abs <= {18'd0, lim_thr_q};
		if (y > 32'sd32767)
			y_clamp = SAMPLE_MAX;
		else if (y < -32'sd32768)
			y_clamp = SAMPLE_MIN;
		else
			y_clamp = y[15:0];

		// soft knee
		lim_c   = {1'b0, lim_thr_q} + {1'b0, quo_q[14:0]};
		lim_sat = lim_c[15] ? SAMPLE_MAX : lim_c;
		lim_res = yneg_q ? (16'd0 - lim_sat) : lim_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lim_thr_q  <= 15'd24576;
			lim_knee_q <= 15'd8192;
			dcl_thr_q  <= 16'd4096;
			ramp_len_q <= 11'd64;
			beta_q     <= 15'd32604;
			seen_q     <= 1'b0;
			last_q     <= '0;
			prev_in_q  <= '0;
			prev_out_q <= '0;
			ramp_act_q <= 1'b0;
			origin_q   <= '0;
			span_q     <= '0;
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
			div_ramp_q <= 1'b0;
			x_q        <= '0;
			dneg_q     <= 1'b0;
			yneg_q     <= 1'b0;
			over_q     <= '0;
			prod_q     <= '0;
			rem_q      <= '0;
			dsor_q     <= '0;
			lo_q       <= '0;
			quo_q      <= '0;
			res_q      <= '0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LIM_THRESHOLD: lim_thr_q  <= cfg_data[14:0];
					REG_LIM_KNEE:      lim_knee_q <= cfg_data[14:0];
					REG_DCL_THRESHOLD: dcl_thr_q  <= cfg_data;
					REG_DCL_RAMP_LEN:  ramp_len_q <= cfg_data[RAMP_W-1:0];
					REG_DC_BETA:       beta_q     <= cfg_data[14:0];
					default: ;
				endcase
			end

			if ((state_q == ST_OUT) && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q <= s_tdata[15:0];
						if (s_tuser) begin
							ramp_act_q <= start_ramp;
							if (start_ramp) begin
								origin_q <= last_q;
								span_q   <= ramp_n;
								pos_q    <= '0;
							end
							state_q <= start_ramp ? ST_RMUL : ST_FMUL;
						end else begin
							state_q <= ramp_act_q ? ST_RMUL : ST_FMUL;
						end
					end
				end
				ST_RMUL: begin
					prod_q  <= mul_p;
					dneg_q  <= d[16];
					state_q <= ST_RLD;
				end
				ST_RLD: begin
					rem_q      <= prod_q[48:16];
					lo_q       <= prod_q[15:0];
					dsor_q     <= {22'd0, span_q};
					quo_q      <= '0;
					cnt_q      <= 5'd16;
					div_ramp_q <= 1'b1;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= div_ge ? div_diff[32:0] : div_t[32:0];
					quo_q <= {quo_q[14:0], div_ge};
					lo_q  <= {lo_q[14:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1)
						state_q <= div_ramp_q ? ST_RFIN : ST_LFIN;
				end
				ST_RFIN: begin
					x_q   <= ramp_x;
					pos_q <= pos_inc;
					if (pos_inc >= span_q)
						ramp_act_q <= 1'b0;
					state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					prod_q  <= mul_p;
					state_q <= ST_FADD;
				end
				ST_FADD: begin
					prev_in_q  <= x_q;
					prev_out_q <= y;
					yneg_q     <= y[31];
					over_q     <= $signed(y_abs - {18'd0, lim_thr_q});
					if (y_small) begin
						res_q   <= y_clamp;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL: begin
					prod_q  <= mul_p;
					state_q <= ST_LLD;
				end
				ST_LLD: begin
					rem_q      <= prod_q[47:15];
					lo_q       <= {prod_q[14:0], 1'b0};
					dsor_q     <= {18'd0, lim_knee_q} + over_q[32:0];
					quo_q      <= '0;
					cnt_q      <= 5'd15;
					div_ramp_q <= 1'b0;
					state_q    <= ST_DIV;
				end
				ST_LFIN: begin
					res_q   <= lim_res;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						last_q     <= res_q;
						seen_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/adcsl_chk.sv]
// port-level checks for the audio declick, dc blocker and soft limiter block
module adcsl_chk
	import adcsl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [IN_DATA_W-1:0] s_tdata,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [SAMPLE_W-1:0]  m_tdata,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	// busy after each request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after a request");

	// ready drops only on a request
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("ready dropped without a request");

	// limiter output never reaches the negative extreme
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != SAMPLE_MIN)
		else $error("output reached the negative extreme");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind audio_declick_dc_block_soft_limit adcsl_chk u_adcsl_chk (.*);
